// ----- sv/cat_pkg.sv -----
// Package for the connection admission table.
// Holds sizes, request and event codes, ring entry and head control types.
// No dependencies.
package cat_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_BITS  = 32;

  // Widths of the device count, the scan step and the limit compare.
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_DETACH   = 1'b1;

  localparam logic [1:0] EV_ATTACHED     = 2'd0;
  localparam logic [1:0] EV_ALREADY      = 2'd1;
  localparam logic [1:0] EV_NOT_ATTACHED = 2'd2;
  localparam logic [1:0] EV_DETACHED     = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [ID_BITS-1:0] id;
  } entry_t;

  // Edit commands for the head of the ring.
  typedef struct packed {
    logic clear_hit;
    logic place;
  } head_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE
  } state_t;

endpackage

// ----- sv/cat_cell.sv -----
// One storage cell of the identifier ring.
// Holds one entry and takes its neighbor's entry on every shift.
// Depends on cat_pkg.
module cat_cell
  import cat_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t entry_in,
  output entry_t entry
);

  // Only the valid bit needs a reset; the id is read only behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry.valid <= entry_in.valid;
    end
    if (shift) begin
      entry.id <= entry_in.id;
    end
  end

endmodule

// ----- sv/cat_head.sv -----
// Head of the identifier ring: match and edit of the entry that closes the ring.
// Compares the entry with the request key, drops a hit or places the key.
// Depends on cat_pkg.
module cat_head
  import cat_pkg::*;
(
  input  head_ctl_t          ctl,
  input  logic [ID_BITS-1:0] key,
  input  entry_t             entry_in,
  output entry_t             entry_out,
  output logic               hit,
  output logic               free
);

  assign hit  = entry_in.valid && (entry_in.id == key);
  assign free = !entry_in.valid;

  always_comb begin
    entry_out = entry_in;
    if (ctl.clear_hit && hit) begin
      entry_out.valid = 1'b0;
    end else if (ctl.place && free) begin
      entry_out.valid = 1'b1;
      entry_out.id    = key;
    end
  end

endmodule

// ----- sv/connection_admission_table.sv -----
// Top level of the connection admission table.
// Ring of cat_cell storage cells closed through cat_head, plus the request sequencer.
// Depends on cat_pkg, cat_cell and cat_head.
//
//   channel   | handshake                 | word
//   ----------+---------------------------+----------------------------------------
//   request   | start, busy               | req_type, device_id
//   result    | done (one-cycle strobe)   | event_code, accepted, active_count
//   config    | max_connections_we        | max_connections
//
// Walk: a register request refused at the limit gets its strobe without a walk.
// Other requests rotate the ring one cell per cycle past the head comparator:
// a hit ends the walk at once, a full walk passes every cell, and a new
// device then rotates on to the first free cell.
// The single comparator at the ring head is why requests walk the ring.
// Reset: synchronous, clears all valid bits and the count, sets the limit to 64.
// busy is high from the accepting edge until the cycle the strobe is shown (a refusal
// at the limit never raises it); the receiver cannot stall, so every result leaves in its strobe cycle.
module connection_admission_table
  import cat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] device_id,
  input  logic        max_connections_we,
  input  logic [6:0]  max_connections,
  output logic        done,
  output logic [1:0]  event_code,
  output logic        accepted,
  output logic [6:0]  active_count
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CAPACITY - 1);

  state_t             state;
  state_t             state_next;
  logic [6:0]         limit_cfg;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  logic               req;
  logic               req_next;
  logic [ID_BITS-1:0] key;
  logic [ID_BITS-1:0] key_next;
  logic               done_next;
  logic [1:0]         code_next;
  logic               acc_next;

  logic [CMP_W-1:0]   limit_eff;
  logic               below_limit;
  logic               rotate;
  head_ctl_t          hctl;
  logic               head_hit;
  logic               head_free;
  entry_t             head_out;
  entry_t             ring [CAPACITY];

  // Ring: each cell takes its upper neighbor, the last cell takes the edited head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_ring
    entry_t cell_in;
    if (i == CAPACITY - 1) begin : g_tail
      assign cell_in = head_out;
    end else begin : g_body
      assign cell_in = ring[i+1];
    end
    cat_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (rotate),
      .entry_in (cell_in),
      .entry    (ring[i])
    );
  end

  cat_head u_head (
    .ctl       (hctl),
    .key       (key),
    .entry_in  (ring[0]),
    .entry_out (head_out),
    .hit       (head_hit),
    .free      (head_free)
  );

  // Clamp the configured limit to the ring size.
  always_comb begin
    if (CMP_W'(limit_cfg) > CMP_W'(CAPACITY)) begin
      limit_eff = CMP_W'(CAPACITY);
    end else begin
      limit_eff = CMP_W'(limit_cfg);
    end
  end

  assign below_limit = CMP_W'(count) < limit_eff;
  assign busy        = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      limit_cfg <= 7'd64;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (max_connections_we) begin
        limit_cfg <= max_connections;
      end
    end
  end

  // Request word and result word; no reset needed.
  always_ff @(posedge clk) begin
    step <= step_next;
    req  <= req_next;
    key  <= key_next;
    if (done_next) begin
      event_code   <= code_next;
      accepted     <= acc_next;
      active_count <= 7'(count_next);
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    step_next  = step;
    req_next   = req;
    key_next   = key;
    done_next  = 1'b0;
    code_next  = EV_DETACHED;
    acc_next   = 1'b0;
    rotate     = 1'b0;
    hctl       = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          req_next  = req_type;
          key_next  = ID_BITS'(device_id);
          step_next = '0;
          if ((req_type == REQ_REGISTER) && !below_limit) begin
            // Refuse at the limit, even for a member.
            done_next = 1'b1;
            code_next = EV_NOT_ATTACHED;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Advance the ring; drop a matching entry on detach.
        rotate         = 1'b1;
        hctl.clear_hit = (req == REQ_DETACH);
        if (head_hit) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
          if (req == REQ_REGISTER) begin
            code_next = EV_ALREADY;
            acc_next  = 1'b1;
          end else begin
            code_next  = EV_DETACHED;
            count_next = count - CNT_W'(1);
          end
        end else if (step == LAST_STEP) begin
          if (req == REQ_REGISTER) begin
            state_next = ST_PLACE;
          end else begin
            // Absent device: report detached, hold the count.
            done_next  = 1'b1;
            code_next  = EV_DETACHED;
            state_next = ST_IDLE;
          end
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_PLACE: begin
        // Rotate on until a free cell reaches the head, then store the key there.
        rotate     = 1'b1;
        hctl.place = 1'b1;
        if (head_free) begin
          done_next  = 1'b1;
          code_next  = EV_ATTACHED;
          acc_next   = 1'b1;
          count_next = count + CNT_W'(1);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
